// ===== src/rtec_pkg.sv =====
// Shared constants, codes and angle helpers for the rotating tower edge recorder.
// Depends on nothing; imported by the top level.
package rtec_pkg;

    // Ring geometry and internal angle width
    localparam int RING_DEPTH = 8;
    localparam int ANGLE_BITS = 16;
    localparam int HEAD_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    // Each channel memory holds a rising ring and a falling ring
    localparam int MEM_AW     = HEAD_W + 1;
    localparam int MEM_DEPTH  = 2 ** MEM_AW;
    // Width used for the barrier window comparison
    localparam int CMP_W      = ((ANGLE_BITS > 15) ? ANGLE_BITS : 15) + 1;

    // Item commands
    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_BARRIER = 2'd1,
        CMD_READ    = 2'd2
    } t_cmd;

    // Edge codes on the result
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_FALL = 2'd2;

    // Ring numbering, following ring_select
    localparam logic [1:0] RING_FIXED_RISE = 2'd0;
    localparam logic [1:0] RING_FIXED_FALL = 2'd1;
    localparam logic [1:0] RING_ROBOT_RISE = 2'd2;
    localparam logic [1:0] RING_ROBOT_FALL = 2'd3;

    // Configuration register indexes (paddr bit 2)
    localparam logic REG_BARRIER_ANGLE  = 1'b0;
    localparam logic REG_BARRIER_WINDOW = 1'b1;

    // Sign-extend a 16-bit angle and keep it modulo 2^ANGLE_BITS.
    function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [15:0] x);
        logic [31:0] t;
        t = {{16{x[15]}}, x};
        return t[ANGLE_BITS-1:0];
    endfunction

    // Low 16 bits of an internal angle, zero-filled when narrower.
    function automatic logic [15:0] angle_out(input logic [ANGLE_BITS-1:0] a);
        logic [31:0] t;
        t = 32'(a);
        return t[15:0];
    endfunction

    // Low 3 bits of a ring head, as reported on the result.
    function automatic logic [2:0] slot_out(input logic [HEAD_W-1:0] h);
        logic [31:0] t;
        t = 32'(h);
        return t[2:0];
    endfunction

    // Advance a ring head with wrap at the ring depth.
    function automatic logic [HEAD_W-1:0] next_head(input logic [HEAD_W-1:0] h);
        logic [HEAD_W:0] t;
        t = {1'b0, h} + 1'b1;
        if (t >= (HEAD_W + 1)'(RING_DEPTH)) begin
            return '0;
        end
        return t[HEAD_W-1:0];
    endfunction

endpackage

// ===== src/rtec_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// Stand-alone; used by the top level for the edge angle rings.
module rtec_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rotating_tower_edge_capture_top.sv =====
// Top level of the rotating tower edge recorder: item stream, APB registers, ring memories.
// Depends on rtec_pkg and rtec_ram.
//
// The block takes one item per clock cycle while the output is not stalled and returns
// exactly one result per item. An accepted item is staged in r_s1 and then moved into the
// output register; a read item issues its ring read at the accepting edge, and the read
// data join the output register as the item moves on. Ring angles live in two synchronous
// memories, one per channel, each holding its rising and falling ring; edge writes happen
// at the accepting edge, so a read item that follows directly sees the new entry. Entries
// never written read as zero through per-entry valid bits cleared at reset, so no clearing
// pass is needed. Heads, levels, barrier side and edge counts are held in flip-flops.
module rotating_tower_edge_capture_top
    import rtec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: rotation_angle[15:0], fixed_seen[16], robot_seen[17], ring_select[19:18],
    //        ring_slot[22:20], zero[23]
    input  logic [23:0] i_s_tdata,
    // tuser: command[1:0]
    input  logic [1:0]  i_s_tuser,
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: fixed_edge[1:0], robot_edge[3:2], fixed_slot[6:4], robot_slot[9:7],
    //        captured_angle[25:10], fixed_rises_last_turn[33:26],
    //        fixed_falls_last_turn[41:34], robot_rises_last_turn[49:42],
    //        robot_falls_last_turn[57:50], turn_latched[58], read_angle[74:59], zero[79:75]
    output logic [79:0] o_m_tdata,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Fields carried from acceptance to the output register
    typedef struct packed {
        logic [1:0]       fixed_edge;
        logic [1:0]       robot_edge;
        logic [2:0]       fixed_slot;
        logic [2:0]       robot_slot;
        logic [15:0]      captured;
        logic [3:0][7:0]  latched;
        logic             turn_latched;
        logic             is_read;
        logic             rd_ok;
        logic             rd_robot;
    } t_stage;

    // Accepted item fields
    t_cmd        s_cmd;
    logic [15:0] s_angle16;
    logic        s_fseen;
    logic        s_rseen;
    logic [1:0]  s_sel;
    logic [2:0]  s_slot;
    logic        s_acc;

    // State registers
    logic                    r_flevel, n_flevel;
    logic                    r_rlevel, n_rlevel;
    logic                    r_side, n_side;
    logic [3:0][HEAD_W-1:0]  r_head, n_head;
    logic [3:0][7:0]         r_run, n_run;
    logic [3:0][7:0]         r_lat, n_lat;
    logic [15:0]             r_ba;
    logic [14:0]             r_bw;
    logic [MEM_DEPTH-1:0]    r_fvld;
    logic [MEM_DEPTH-1:0]    r_rvld;

    // Pipeline registers
    t_stage                  r_s1, n_s1;
    logic                    r_s1_vld;
    logic [79:0]             r_out;
    logic                    r_out_vld;
    logic                    s1_adv;

    // Memory ports
    logic                    f_we, rb_we;
    logic [MEM_AW-1:0]       f_waddr, rb_waddr;
    logic [ANGLE_BITS-1:0]   s_angle;
    logic                    rd_re;
    logic [MEM_AW-1:0]       rd_addr;
    logic [ANGLE_BITS-1:0]   f_rdata, rb_rdata;

    // Combinational working values
    logic                    s_latch;
    logic [ANGLE_BITS-1:0]   diff;
    logic                    side;
    logic [ANGLE_BITS:0]     neg_mag;
    logic [CMP_W-1:0]        mag;
    logic [31:0]             slot32;
    logic [15:0]             read_angle;
    logic                    cfg_we;

    // Unpack the input item
    assign s_cmd     = t_cmd'(i_s_tuser);
    assign s_angle16 = i_s_tdata[15:0];
    assign s_fseen   = i_s_tdata[16];
    assign s_rseen   = i_s_tdata[17];
    assign s_sel     = i_s_tdata[19:18];
    assign s_slot    = i_s_tdata[22:20];
    assign s_angle   = to_angle(s_angle16);

    // Handshake: the staged item moves on when the output register is free or drains
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || s1_adv;
    assign s_acc      = i_s_tvalid && o_s_tready;

    // Barrier difference and its magnitude
    assign diff    = s_angle - to_angle(r_ba);
    assign side    = ~diff[ANGLE_BITS-1];
    assign neg_mag = {1'b1, {ANGLE_BITS{1'b0}}} - {1'b0, diff};
    assign mag     = side ? CMP_W'(diff) : CMP_W'(neg_mag);
    assign slot32  = 32'(s_slot);

    // Next state and the staged result of the item being accepted
    always_comb begin
        n_flevel = r_flevel;
        n_rlevel = r_rlevel;
        n_side   = r_side;
        n_head   = r_head;
        n_run    = r_run;
        n_lat    = r_lat;
        s_latch  = 1'b0;
        f_we     = 1'b0;
        rb_we    = 1'b0;
        f_waddr  = '0;
        rb_waddr = '0;
        rd_re    = 1'b0;
        rd_addr  = {s_sel[0], slot32[HEAD_W-1:0]};
        n_s1     = '0;
        case (s_cmd)
            CMD_SAMPLE: begin
                // Fixed beacon channel
                if (s_fseen != r_flevel) begin
                    n_flevel = s_fseen;
                    f_we     = s_acc;
                    if (s_fseen) begin
                        n_head[RING_FIXED_RISE] = next_head(r_head[RING_FIXED_RISE]);
                        if (r_run[RING_FIXED_RISE] != 8'hFF) begin
                            n_run[RING_FIXED_RISE] = r_run[RING_FIXED_RISE] + 8'd1;
                        end
                        f_waddr           = {1'b0, n_head[RING_FIXED_RISE]};
                        n_s1.fixed_edge   = EDGE_RISE;
                        n_s1.fixed_slot   = slot_out(n_head[RING_FIXED_RISE]);
                    end else begin
                        n_head[RING_FIXED_FALL] = next_head(r_head[RING_FIXED_FALL]);
                        if (r_run[RING_FIXED_FALL] != 8'hFF) begin
                            n_run[RING_FIXED_FALL] = r_run[RING_FIXED_FALL] + 8'd1;
                        end
                        f_waddr           = {1'b1, n_head[RING_FIXED_FALL]};
                        n_s1.fixed_edge   = EDGE_FALL;
                        n_s1.fixed_slot   = slot_out(n_head[RING_FIXED_FALL]);
                    end
                end
                // Robot channel
                if (s_rseen != r_rlevel) begin
                    n_rlevel = s_rseen;
                    rb_we    = s_acc;
                    if (s_rseen) begin
                        n_head[RING_ROBOT_RISE] = next_head(r_head[RING_ROBOT_RISE]);
                        if (r_run[RING_ROBOT_RISE] != 8'hFF) begin
                            n_run[RING_ROBOT_RISE] = r_run[RING_ROBOT_RISE] + 8'd1;
                        end
                        rb_waddr          = {1'b0, n_head[RING_ROBOT_RISE]};
                        n_s1.robot_edge   = EDGE_RISE;
                        n_s1.robot_slot   = slot_out(n_head[RING_ROBOT_RISE]);
                    end else begin
                        n_head[RING_ROBOT_FALL] = next_head(r_head[RING_ROBOT_FALL]);
                        if (r_run[RING_ROBOT_FALL] != 8'hFF) begin
                            n_run[RING_ROBOT_FALL] = r_run[RING_ROBOT_FALL] + 8'd1;
                        end
                        rb_waddr          = {1'b1, n_head[RING_ROBOT_FALL]};
                        n_s1.robot_edge   = EDGE_FALL;
                        n_s1.robot_slot   = slot_out(n_head[RING_ROBOT_FALL]);
                    end
                end
                if ((s_fseen != r_flevel) || (s_rseen != r_rlevel)) begin
                    n_s1.captured = angle_out(s_angle);
                end
            end
            CMD_BARRIER: begin
                // A sign flip near the barrier closes the turn
                if (side != r_side) begin
                    n_side = side;
                    if (mag < CMP_W'(r_bw)) begin
                        s_latch = 1'b1;
                        n_lat   = r_run;
                        n_run   = '0;
                    end
                end
            end
            CMD_READ: begin
                rd_re         = s_acc;
                n_s1.is_read  = 1'b1;
                n_s1.rd_robot = s_sel[1];
                n_s1.rd_ok    = (slot32 < 32'(RING_DEPTH)) &&
                                (s_sel[1] ? r_rvld[rd_addr] : r_fvld[rd_addr]);
            end
            default: begin
            end
        endcase
        n_s1.latched      = n_lat;
        n_s1.turn_latched = s_latch;
    end

    // Edge state, counts and valid bits change only on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flevel <= 1'b0;
            r_rlevel <= 1'b0;
            r_side   <= 1'b0;
            r_head   <= {4{HEAD_W'(RING_DEPTH - 1)}};
            r_run    <= '0;
            r_lat    <= '0;
            r_fvld   <= '0;
            r_rvld   <= '0;
        end else if (s_acc) begin
            r_flevel <= n_flevel;
            r_rlevel <= n_rlevel;
            r_side   <= n_side;
            r_head   <= n_head;
            r_run    <= n_run;
            r_lat    <= n_lat;
            if (f_we) begin
                r_fvld[f_waddr] <= 1'b1;
            end
            if (rb_we) begin
                r_rvld[rb_waddr] <= 1'b1;
            end
        end
    end

    // Ring memories, one per channel
    rtec_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (ANGLE_BITS)
    ) u_fixed_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (s_angle),
        .i_re    (rd_re && !s_sel[1]),
        .i_raddr (rd_addr),
        .o_rdata (f_rdata)
    );

    rtec_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (ANGLE_BITS)
    ) u_robot_ram (
        .i_clk   (i_clk),
        .i_we    (rb_we),
        .i_waddr (rb_waddr),
        .i_wdata (s_angle),
        .i_re    (rd_re && s_sel[1]),
        .i_raddr (rd_addr),
        .o_rdata (rb_rdata)
    );

    // Staged item, waiting for its memory data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1 <= n_s1;
        end
    end

    // Merge the ring read into the result
    always_comb begin
        read_angle = 16'd0;
        if (r_s1.is_read && r_s1.rd_ok) begin
            read_angle = angle_out(r_s1.rd_robot ? rb_rdata : f_rdata);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= {5'd0, read_angle, r_s1.turn_latched,
                      r_s1.latched[RING_ROBOT_FALL], r_s1.latched[RING_ROBOT_RISE],
                      r_s1.latched[RING_FIXED_FALL], r_s1.latched[RING_FIXED_RISE],
                      r_s1.captured, r_s1.robot_slot, r_s1.fixed_slot,
                      r_s1.robot_edge, r_s1.fixed_edge};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ba <= 16'hA000;
            r_bw <= 15'd5215;
        end else if (cfg_we) begin
            if (paddr[2] == REG_BARRIER_WINDOW) begin
                r_bw <= pwdata[14:0];
            end else begin
                r_ba <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_BARRIER_ANGLE) begin
            prdata = {{16{r_ba[15]}}, r_ba};
        end else begin
            prdata = {17'd0, r_bw};
        end
    end

`ifndef SYNTHESIS
    // A latching barrier item leaves every running count at zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_latch) |=> (r_run == '0))
        else $error("running counts not cleared after a turn latch");

    // A result without an edge carries no captured angle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] == EDGE_NONE && o_m_tdata[3:2] == EDGE_NONE)
        |-> (o_m_tdata[25:10] == 16'd0))
        else $error("captured angle set without an edge");

    // An accepted item is always staged in the following cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_s1_vld)
        else $error("accepted item lost before staging");

    // A staged item that cannot move on blocks the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |-> !o_s_tready)
        else $error("staged item could be overwritten");
`endif

endmodule

// ===== sim/rotating_tower_edge_capture_top_test.sv =====
// Self-checking testbench for the rotating tower edge recorder: directed, saturation, stall
// and random turn tests, checked item by item against an in-bench prediction of the block.
// Depends on rtec_pkg and rotating_tower_edge_capture_top.
module rotating_tower_edge_capture_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rtec_pkg::*;

    // Command code that the block must ignore
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int LONG_HOLD   = 200;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        logic [1:0]  command;
        logic [15:0] angle;
        logic        fixed_seen;
        logic        robot_seen;
        logic [1:0]  ring_select;
        logic [2:0]  ring_slot;
    } t_item;

    typedef struct {
        logic [1:0]  fixed_edge;
        logic [1:0]  robot_edge;
        logic [2:0]  fixed_slot;
        logic [2:0]  robot_slot;
        logic [15:0] captured_angle;
        logic [7:0]  fixed_rises;
        logic [7:0]  fixed_falls;
        logic [7:0]  robot_rises;
        logic [7:0]  robot_falls;
        logic        turn_latched;
        logic [15:0] read_angle;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [79:0] o_m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rotating_tower_edge_capture_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Predicted state of the recorder
    logic        fixed_level;
    logic        robot_level;
    logic        barrier_side;
    logic [2:0]  ring_heads [4];
    logic [7:0]  running_counts [4];
    logic [7:0]  held_counts [4];
    logic [15:0] edge_rings [4][RING_DEPTH];
    logic [15:0] cfg_barrier;
    logic [14:0] cfg_window;

    // Results still owed by the block, oldest first
    t_result pending_results [$];
    int      mismatch_count;

    // Stimulus shaping
    bit          sender_idle;
    bit          receiver_idle;
    bit          long_hold_req;
    logic [15:0] rot_angle;
    logic        drv_fixed;
    logic        drv_robot;

    // Clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap length: mostly none, sometimes short, rarely long
    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic t_item mk(input logic [1:0] cmd, input logic [15:0] angle,
                                 input logic fseen, input logic rseen,
                                 input logic [1:0] sel, input logic [2:0] slot);
        t_item it;
        it.command     = cmd;
        it.angle       = angle;
        it.fixed_seen  = fseen;
        it.robot_seen  = rseen;
        it.ring_select = sel;
        it.ring_slot   = slot;
        return it;
    endfunction

    function automatic t_item check_at(input int angle);
        return mk(CMD_BARRIER, 16'(angle), 1'b0, 1'b0, RING_FIXED_RISE, 3'd0);
    endfunction

    function automatic void reset_tower_model();
        fixed_level  = 1'b0;
        robot_level  = 1'b0;
        barrier_side = 1'b0;
        cfg_barrier  = 16'hA000;
        cfg_window   = 15'd5215;
        for (int i = 0; i < 4; i++) begin
            ring_heads[i]     = 3'(RING_DEPTH - 1);
            running_counts[i] = '0;
            held_counts[i]    = '0;
            for (int j = 0; j < RING_DEPTH; j++) begin
                edge_rings[i][j] = '0;
            end
        end
    endfunction

    // Advance a ring head, store the angle there and count the edge.
    function automatic logic [2:0] store_edge(input logic [1:0] ring, input logic [15:0] angle);
        if (ring_heads[ring] == 3'(RING_DEPTH - 1)) begin
            ring_heads[ring] = '0;
        end else begin
            ring_heads[ring] = ring_heads[ring] + 3'd1;
        end
        if (running_counts[ring] != 8'd255) begin
            running_counts[ring] = running_counts[ring] + 8'd1;
        end
        edge_rings[ring][ring_heads[ring]] = angle;
        return ring_heads[ring];
    endfunction

    // Work out the result of one accepted item and update the predicted state.
    function automatic t_result tower_predict(input t_item it);
        t_result     res;
        logic [15:0] diff;
        logic [16:0] mag;
        logic        new_side;
        res = '{default: '0};
        case (it.command)
            CMD_SAMPLE: begin
                if (it.fixed_seen != fixed_level) begin
                    fixed_level    = it.fixed_seen;
                    res.fixed_edge = it.fixed_seen ? EDGE_RISE : EDGE_FALL;
                    res.fixed_slot = store_edge(it.fixed_seen ? RING_FIXED_RISE
                                                              : RING_FIXED_FALL, it.angle);
                end
                if (it.robot_seen != robot_level) begin
                    robot_level    = it.robot_seen;
                    res.robot_edge = it.robot_seen ? EDGE_RISE : EDGE_FALL;
                    res.robot_slot = store_edge(it.robot_seen ? RING_ROBOT_RISE
                                                              : RING_ROBOT_FALL, it.angle);
                end
                if (res.fixed_edge != EDGE_NONE || res.robot_edge != EDGE_NONE) begin
                    res.captured_angle = it.angle;
                end
            end
            CMD_BARRIER: begin
                // Wrapped distance from the barrier; negative side is 0
                diff     = it.angle - cfg_barrier;
                new_side = ~diff[15];
                mag      = new_side ? {1'b0, diff} : 17'h10000 - {1'b0, diff};
                if (new_side != barrier_side) begin
                    barrier_side = new_side;
                    if (mag < {2'b00, cfg_window}) begin
                        for (int i = 0; i < 4; i++) begin
                            held_counts[i]    = running_counts[i];
                            running_counts[i] = '0;
                        end
                        res.turn_latched = 1'b1;
                    end
                end
            end
            CMD_READ: begin
                res.read_angle = edge_rings[it.ring_select][it.ring_slot];
            end
            default: begin
            end
        endcase
        res.fixed_rises = held_counts[RING_FIXED_RISE];
        res.fixed_falls = held_counts[RING_FIXED_FALL];
        res.robot_rises = held_counts[RING_ROBOT_RISE];
        res.robot_falls = held_counts[RING_ROBOT_FALL];
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offer one item after a random gap and record its expected result once taken.
    task automatic send_item(input t_item it);
        int gap;
        gap = pick_gap(sender_idle);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tuser  = it.command;
        i_s_tdata  = {1'b0, it.ring_slot, it.ring_select, it.robot_seen, it.fixed_seen,
                      it.angle};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(tower_predict(it));
        @(negedge i_clk);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_idle();
        i_s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic idx, input bit wr, input logic [31:0] data,
                              output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write both registers while idle and read them back.
    task automatic set_config(input logic [15:0] barrier, input logic [14:0] window);
        logic [31:0] rd;
        wait_idle();
        apb_access(REG_BARRIER_ANGLE, 1'b1, {16'd0, barrier}, rd);
        apb_access(REG_BARRIER_WINDOW, 1'b1, {17'd0, window}, rd);
        cfg_barrier = barrier;
        cfg_window  = window;
        apb_access(REG_BARRIER_ANGLE, 1'b0, '0, rd);
        check_field("barrier_angle readback", cfg_barrier, rd[15:0]);
        apb_access(REG_BARRIER_WINDOW, 1'b0, '0, rd);
        check_field("barrier_window readback", cfg_window, rd[14:0]);
    endtask

    // Next item of a spinning tower: mostly samples and barrier checks, some reads and noise.
    function automatic t_item make_turn_item();
        t_item it;
        int    r;
        int    w;
        int    offs;
        r  = $urandom_range(0, 99);
        it = mk(CMD_SAMPLE, '0, 1'b0, 1'b0, 2'($urandom), 3'($urandom));
        if ($urandom_range(0, 19) == 0) begin
            rot_angle = 16'($urandom);
        end else begin
            rot_angle = rot_angle + 16'($urandom_range(0, 2500));
        end
        it.angle = rot_angle;
        if (r < 55) begin
            if ($urandom_range(0, 9) < 3) drv_fixed = ~drv_fixed;
            if ($urandom_range(0, 9) < 3) drv_robot = ~drv_robot;
            it.fixed_seen = drv_fixed;
            it.robot_seen = drv_robot;
        end else if (r < 80) begin
            it.command = CMD_BARRIER;
            if ($urandom_range(0, 1) == 1) begin
                w = int'(cfg_window) + 200;
                if (w > 20000) w = 20000;
                offs     = int'($urandom_range(0, 2 * w)) - w;
                it.angle = cfg_barrier + 16'(offs);
            end
            it.fixed_seen = 1'($urandom);
            it.robot_seen = 1'($urandom);
        end else if (r < 95) begin
            it.command    = CMD_READ;
            it.fixed_seen = 1'($urandom);
            it.robot_seen = 1'($urandom);
        end else begin
            // Noise: any command with arbitrary fields
            it = mk(2'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                    2'($urandom), 3'($urandom));
            if (it.command == CMD_SAMPLE) begin
                drv_fixed = it.fixed_seen;
                drv_robot = it.robot_seen;
            end
        end
        return it;
    endfunction

    // Edges on both channels, ring reads and the ignored command.
    task automatic test_directed_edges();
        send_item(mk(CMD_READ, '0, 1'b0, 1'b0, RING_FIXED_RISE, 3'd7));
        send_item(mk(CMD_SAMPLE, 16'h7FFF, 1'b1, 1'b0, RING_FIXED_RISE, 3'd0));
        send_item(mk(CMD_SAMPLE, 16'h8000, 1'b1, 1'b1, RING_FIXED_RISE, 3'd0));
        send_item(mk(CMD_SAMPLE, 16'h0000, 1'b0, 1'b0, RING_ROBOT_FALL, 3'd7));
        send_item(mk(CMD_SAMPLE, 16'h0001, 1'b1, 1'b1, RING_FIXED_RISE, 3'd0));
        send_item(mk(CMD_SAMPLE, 16'h1234, 1'b1, 1'b1, RING_FIXED_RISE, 3'd0));
        send_item(mk(CMD_SPARE, 16'hFFFF, 1'b1, 1'b1, RING_ROBOT_FALL, 3'd7));
        send_item(mk(CMD_READ, '0, 1'b0, 1'b0, RING_FIXED_RISE, 3'd1));
        send_item(mk(CMD_READ, 16'hFFFF, 1'b1, 1'b1, RING_ROBOT_FALL, 3'd0));
        send_item(mk(CMD_READ, '0, 1'b0, 1'b0, RING_FIXED_FALL, 3'd0));
        drv_fixed = 1'b1;
        drv_robot = 1'b1;
    endtask

    // Barrier crossings with the reset settings: on the barrier, half a turn away, window edges.
    task automatic test_barrier_crossings();
        send_item(check_at(-24576));
        send_item(check_at(8192));
        send_item(check_at(-24576));
        send_item(check_at(-24577));
        send_item(check_at(-24576 + 5215));
        send_item(check_at(-24576 - 5214));
        send_item(check_at(-24576 - 100));
    endtask

    // Enough edges in one turn to pin every running count at its ceiling.
    task automatic test_count_saturation();
        for (int i = 0; i < 520; i++) begin
            drv_fixed = ~drv_fixed;
            drv_robot = ~drv_robot;
            send_item(mk(CMD_SAMPLE, 16'($urandom), drv_fixed, drv_robot,
                         2'($urandom), 3'($urandom)));
        end
        send_item(check_at(-24576));
        send_item(check_at(-24577));
    endtask

    task automatic test_tower_turns(input int count, input bit idle);
        sender_idle   = idle;
        receiver_idle = idle;
        for (int i = 0; i < count; i++) begin
            send_item(make_turn_item());
        end
    endtask

    // Hold the output off for a long time while items keep coming, filling the block.
    task automatic test_output_stall();
        sender_idle   = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 60; i++) begin
            send_item(make_turn_item());
        end
        wait_idle();
    endtask

    // Result side ready: random gaps, plus the long hold when asked for
    initial begin
        int rdy_gap;
        rdy_gap    = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rdy_gap       = LONG_HOLD;
            end
            if (rdy_gap > 0) begin
                i_m_tready = 1'b0;
                rdy_gap--;
            end else begin
                i_m_tready = 1'b1;
                rdy_gap    = pick_gap(receiver_idle);
            end
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge i_clk) begin : check_result
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.fixed_edge     = o_m_tdata[1:0];
            got.robot_edge     = o_m_tdata[3:2];
            got.fixed_slot     = o_m_tdata[6:4];
            got.robot_slot     = o_m_tdata[9:7];
            got.captured_angle = o_m_tdata[25:10];
            got.fixed_rises    = o_m_tdata[33:26];
            got.fixed_falls    = o_m_tdata[41:34];
            got.robot_rises    = o_m_tdata[49:42];
            got.robot_falls    = o_m_tdata[57:50];
            got.turn_latched   = o_m_tdata[58];
            got.read_angle     = o_m_tdata[74:59];
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with none expected, expected nothing, actual %h",
                         $time, o_m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("fixed_edge", want.fixed_edge, got.fixed_edge);
                check_field("robot_edge", want.robot_edge, got.robot_edge);
                check_field("fixed_slot", want.fixed_slot, got.fixed_slot);
                check_field("robot_slot", want.robot_slot, got.robot_slot);
                check_field("captured_angle", want.captured_angle, got.captured_angle);
                check_field("fixed_rises_last_turn", want.fixed_rises, got.fixed_rises);
                check_field("fixed_falls_last_turn", want.fixed_falls, got.fixed_falls);
                check_field("robot_rises_last_turn", want.robot_rises, got.robot_rises);
                check_field("robot_falls_last_turn", want.robot_falls, got.robot_falls);
                check_field("turn_latched", want.turn_latched, got.turn_latched);
                check_field("read_angle", want.read_angle, got.read_angle);
            end
        end
    end

    // Watchdog: too many cycles with no transfer on any port ends the run
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        sender_idle    = 1'b1;
        receiver_idle  = 1'b1;
        long_hold_req  = 1'b0;
        rot_angle      = '0;
        drv_fixed      = 1'b0;
        drv_robot      = 1'b0;
        reset_tower_model();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_edges();
        test_barrier_crossings();
        test_count_saturation();
        set_config(16'h7FFF, 15'h7FFF);
        test_tower_turns(300, 1'b1);
        set_config(16'h8000, 15'h0000);
        test_tower_turns(250, 1'b0);
        test_output_stall();
        repeat (2) begin
            set_config(16'($urandom), 15'($urandom_range(0, 32767)));
            test_tower_turns(200, 1'b1);
        end

        // Drain, then allow time for any stray result
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
